// ===== hdl/esc_pkg.sv =====
// esc_pkg: fixed-point types, constants and arithmetic helpers for the
// environmental sensor compensation pipeline; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DIV_STEPS = 64;
  // divider: one prelude stage, one stage per quotient bit, one result stage
  localparam int DIV_LAT   = DIV_STEPS + 2;

  typedef logic signed [63:0] fx_t;

  // partial products of a 64x64 magnitude multiply
  typedef struct packed {
    logic        neg;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p10;
    logic [63:0] p11;
  } mpp_t;

  localparam fx_t FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 64'sh8000_0000_0000_0000;

  function automatic logic [63:0] mag_of(fx_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic fx_t from_mag(logic neg, logic [63:0] m);
    logic [63:0] c;
    c = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    return neg ? fx_t'(~c + 64'd1) : fx_t'(c);
  endfunction

  // integer to fixed point, saturating
  function automatic fx_t fx_from(fx_t n);
    fx_t lim;
    lim = FX_MAX >>> FRAC_BITS;
    if (n > lim) return FX_MAX;
    if (n < -lim) return -FX_MAX;
    return n <<< FRAC_BITS;
  endfunction

  function automatic fx_t fx_add(fx_t a, fx_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return fx_t'(s[63:0]);
  endfunction

  function automatic fx_t fx_sub(fx_t a, fx_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
    return fx_t'(s[63:0]);
  endfunction

  // rounded division by 2^s on the magnitude, ties away from zero
  function automatic fx_t fx_shr(fx_t a, int s);
    logic [64:0] t;
    t = ({1'b0, mag_of(a)} + (65'd1 << (s - 1))) >> s;
    return from_mag(a[63], t[63:0]);
  endfunction

  function automatic mpp_t mul_pp(fx_t a, fx_t b);
    mpp_t        r;
    logic [63:0] ua;
    logic [63:0] ub;
    ua    = mag_of(a);
    ub    = mag_of(b);
    r.neg = a[63] ^ b[63];
    r.p00 = {32'd0, ua[31:0]} * {32'd0, ub[31:0]};
    r.p01 = {32'd0, ua[31:0]} * {32'd0, ub[63:32]};
    r.p10 = {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
    r.p11 = {32'd0, ua[63:32]} * {32'd0, ub[63:32]};
    return r;
  endfunction

  function automatic fx_t mul_fin(mpp_t p);
    logic [127:0] s;
    logic [63:0]  m;
    s = {64'd0, p.p00} + ({64'd0, p.p01} << 32) + ({64'd0, p.p10} << 32)
      + {p.p11, 64'd0};
    s = (s + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    m = (|s[127:64]) ? '1 : s[63:0];
    return from_mag(p.neg, m);
  endfunction

  localparam fx_t FX_ONE  = fx_from(64'sd1);
  localparam fx_t FX_5    = fx_from(64'sd5);
  localparam fx_t FX_100  = fx_from(64'sd100);
  localparam fx_t FX_6250 = fx_from(64'sd6250);
  localparam fx_t FX_64K  = fx_from(64'sd64000);
  localparam fx_t FX_768H = fx_from(64'sd76800);

endpackage
`default_nettype wire

// ===== hdl/esc_div.sv =====
// esc_div: pipelined restoring divider for the fixed-point pressure quotient
// depends on esc_pkg
`timescale 1ns / 1ps
`default_nettype none
module esc_div (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire esc_pkg::fx_t  num,
  input  wire esc_pkg::fx_t  den,
  output esc_pkg::fx_t       quo
);
  import esc_pkg::*;

  logic [63:0] rem     [0:DIV_STEPS];
  logic [63:0] qbits   [0:DIV_STEPS];
  logic [63:0] dividend[0:DIV_STEPS];
  logic [63:0] divisor [0:DIV_STEPS];
  logic        neg     [0:DIV_STEPS];
  logic        ovf     [0:DIV_STEPS];
  logic        dzero   [0:DIV_STEPS];

  logic [127:0] pre_n;
  logic [63:0]  pre_ua;
  logic [63:0]  pre_ub;

  // scale numerator by 2^frac and add half the divisor for rounding
  always_comb begin
    pre_ua = mag_of(num);
    pre_ub = mag_of(den);
    pre_n  = ({64'd0, pre_ua} << FRAC_BITS) + {65'd0, pre_ub[63:1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]      <= pre_n[127:64];
      dividend[0] <= pre_n[63:0];
      divisor[0]  <= pre_ub;
      qbits[0]    <= '0;
      neg[0]      <= num[63] ^ den[63];
      ovf[0]      <= pre_n[127:64] >= pre_ub;
      dzero[0]    <= pre_ub == 64'd0;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    logic [64:0] rsh;
    logic        take;
    always_comb begin
      rsh  = {rem[j-1], dividend[j-1][DIV_STEPS-j]};
      take = rsh >= {1'b0, divisor[j-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j]      <= take ? 64'(rsh - {1'b0, divisor[j-1]}) : rsh[63:0];
        qbits[j]    <= {qbits[j-1][62:0], take};
        dividend[j] <= dividend[j-1];
        divisor[j]  <= divisor[j-1];
        neg[j]      <= neg[j-1];
        ovf[j]      <= ovf[j-1];
        dzero[j]    <= dzero[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dzero[DIV_STEPS]) begin
        quo <= '0;
      end else if (ovf[DIV_STEPS]) begin
        quo <= from_mag(neg[DIV_STEPS], '1);
      end else begin
        quo <= from_mag(neg[DIV_STEPS], qbits[DIV_STEPS]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/env_sensor_compensation.sv =====
// env_sensor_compensation: top level, calibration registers and the
// compensation pipeline; depends on esc_pkg and esc_div
`timescale 1ns / 1ps
`default_nettype none
// Compensates one raw sample (pressure, temperature, humidity) per transaction
// using calibration words written over the register port. One sample enters
// per clock while the output is not stalled, and the pipeline depth is set
// mostly by the pressure divider, which resolves one quotient bit per
// pipeline stage over 64 stages. The whole pipeline advances together and
// holds when the output register is full and not taken, so nothing is lost
// or repeated under back-pressure. Multiplies are split into 32x32 partial
// products in one stage and summed, rounded and saturated in the next.
// Calibration registers must only be written while the pipeline is empty.
// Register map (64-bit data, byte address 8*i): temp_calib 0x00,
// press_calib_a 0x08, press_calib_b 0x10, press_calib_nine 0x18,
// hum_calib 0x20.
module env_sensor_compensation (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // raw sample stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,  // raw_pressure, raw_temperature, raw_humidity
  // compensated result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,  // temperature_centi, pressure_pa, humidity_centi
  output logic             m_tuser   // pressure_invalid
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    REG_TEMP_CALIB       = 3'd0,
    REG_PRESS_CALIB_A    = 3'd1,
    REG_PRESS_CALIB_B    = 3'd2,
    REG_PRESS_CALIB_NINE = 3'd3,
    REG_HUM_CALIB        = 3'd4
  } reg_idx_t;

  // stage numbering
  localparam int ST_INV     = 17;
  localparam int ST_DIV_OUT = ST_INV + DIV_LAT;
  localparam int ST_OUT     = ST_DIV_OUT + 7;
  localparam int ST_TC      = 9;
  localparam int ST_HUM     = 25;
  localparam int ST_RP_LAST = 14;
  localparam int ST_RH_LAST = 11;

  // ---------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------
  logic [47:0] temp_calib;
  logic [63:0] press_calib_a;
  logic [63:0] press_calib_b;
  logic [15:0] press_calib_nine;
  logic [63:0] hum_calib;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_a    <= '0;
      press_calib_b    <= '0;
      press_calib_nine <= '0;
      hum_calib        <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_TEMP_CALIB:       temp_calib       <= pwdata[47:0];
        REG_PRESS_CALIB_A:    press_calib_a    <= pwdata;
        REG_PRESS_CALIB_B:    press_calib_b    <= pwdata;
        REG_PRESS_CALIB_NINE: press_calib_nine <= pwdata[15:0];
        REG_HUM_CALIB:        hum_calib        <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_TEMP_CALIB:       prdata = {16'd0, temp_calib};
      REG_PRESS_CALIB_A:    prdata = press_calib_a;
      REG_PRESS_CALIB_B:    prdata = press_calib_b;
      REG_PRESS_CALIB_NINE: prdata = {48'd0, press_calib_nine};
      REG_HUM_CALIB:        prdata = hum_calib;
      default:              prdata = '0;
    endcase
  end

  // coefficients in fixed point; the user must keep them static while samples are in flight (not enforced)
  fx_t c_t1s10, c_t1s13, c_t2, c_t3;
  fx_t c_p1, c_p2, c_p3, c_p4, c_p5x2, c_p6, c_p7, c_p8, c_p9;
  fx_t c_h1, c_h2, c_h3, c_h4, c_h5, c_h6;

  always_comb begin
    c_t1s10 = fx_shr(fx_from({48'd0, temp_calib[15:0]}), 10);
    c_t1s13 = fx_shr(fx_from({48'd0, temp_calib[15:0]}), 13);
    c_t2    = fx_from(fx_t'(signed'(temp_calib[31:16])));
    c_t3    = fx_from(fx_t'(signed'(temp_calib[47:32])));
    c_p1    = fx_from({48'd0, press_calib_a[15:0]});
    c_p2    = fx_from(fx_t'(signed'(press_calib_a[31:16])));
    c_p3    = fx_from(fx_t'(signed'(press_calib_a[47:32])));
    c_p4    = fx_from(fx_t'(signed'(press_calib_a[63:48])) <<< 16);
    c_p5x2  = fx_from(fx_t'(signed'(press_calib_b[15:0])) <<< 1);
    c_p6    = fx_from(fx_t'(signed'(press_calib_b[31:16])));
    c_p7    = fx_from(fx_t'(signed'(press_calib_b[47:32])));
    c_p8    = fx_from(fx_t'(signed'(press_calib_b[63:48])));
    c_p9    = fx_from(fx_t'(signed'(press_calib_nine)));
    c_h1    = fx_from({56'd0, hum_calib[7:0]});
    c_h2    = fx_from(fx_t'(signed'(hum_calib[23:8])));
    c_h3    = fx_from({56'd0, hum_calib[31:24]});
    c_h4    = fx_from(fx_t'(signed'(hum_calib[43:32])) <<< 6);
    c_h5    = fx_from(fx_t'(signed'(hum_calib[55:44])));
    c_h6    = fx_from(fx_t'(signed'(hum_calib[63:56])));
  end

  // ---------------------------------------------------------------------
  // pipeline control: every stage moves together
  // ---------------------------------------------------------------------
  logic [1:ST_OUT] vld;
  logic            en;

  assign en       = !vld[ST_OUT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {s_tvalid, vld[1:ST_OUT-1]};
    end
  end

  logic [19:0] in_rp, in_rt;
  logic [15:0] in_rh;
  assign in_rp = s_tdata[19:0];
  assign in_rt = s_tdata[39:20];
  assign in_rh = s_tdata[55:40];

  // raw pressure and humidity ride along until they are needed
  logic [19:0] rp_d [1:ST_RP_LAST];
  logic [15:0] rh_d [1:ST_RH_LAST];

  always_ff @(posedge clk) begin
    if (en) begin
      rp_d[1] <= in_rp;
      rh_d[1] <= in_rh;
      for (int k = 2; k <= ST_RP_LAST; k++) rp_d[k] <= rp_d[k-1];
      for (int k = 2; k <= ST_RH_LAST; k++) rh_d[k] <= rh_d[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // temperature, stages 1..9
  // ---------------------------------------------------------------------
  fx_t  s1_ta, s1_tb;
  mpp_t s2_a_pp, s2_b_pp;
  fx_t  s3_v1, s3_bb;
  mpp_t s4_pp;
  fx_t  s4_v1;
  fx_t  s5_v1, s5_v2;
  fx_t  s6_tsum;
  mpp_t s7_pp;
  fx_t  s7_tf;
  fx_t  s8_tmul, s8_pv1, s8_hd;
  fx_t  s9_tc;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta   <= fx_sub(fx_shr(fx_from({44'd0, in_rt}), 14), c_t1s10);
      s1_tb   <= fx_sub(fx_shr(fx_from({44'd0, in_rt}), 17), c_t1s13);
      s2_a_pp <= mul_pp(s1_ta, c_t2);
      s2_b_pp <= mul_pp(s1_tb, s1_tb);
      s3_v1   <= mul_fin(s2_a_pp);
      s3_bb   <= mul_fin(s2_b_pp);
      s4_pp   <= mul_pp(s3_bb, c_t3);
      s4_v1   <= s3_v1;
      s5_v2   <= mul_fin(s4_pp);
      s5_v1   <= s4_v1;
      s6_tsum <= fx_add(s5_v1, s5_v2);
      s7_pp   <= mul_pp(s6_tsum, FX_5);
      // fine temperature: integer part truncated toward zero
      s7_tf   <= fx_from(from_mag(s6_tsum[63], mag_of(s6_tsum) >> FRAC_BITS));
      s8_tmul <= mul_fin(s7_pp);
      s8_pv1  <= fx_sub(fx_shr(s7_tf, 1), FX_64K);
      s8_hd   <= fx_sub(s7_tf, FX_768H);
      s9_tc   <= fx_shr(s8_tmul, FRAC_BITS + 8);
    end
  end

  // ---------------------------------------------------------------------
  // pressure divisor and numerator, stages 9..17
  // ---------------------------------------------------------------------
  mpp_t s9_sq_pp, s9_m5_pp, s9_m3_pp, s9_m2_pp;
  fx_t  s9_pv1;
  fx_t  s10_sq, s10_m5, s10_m3, s10_m2, s10_pv1;
  mpp_t s11_x6_pp, s11_x3_pp;
  fx_t  s11_m5, s11_m2;
  fx_t  s12_x6, s12_x3, s12_m5, s12_m2;
  fx_t  s13_v2a, s13_v1a;
  fx_t  s14_v2b, s14_v1b;
  mpp_t s15_den_pp;
  fx_t  s15_pd;
  fx_t  s16_den;
  mpp_t s16_num_pp;
  fx_t  s17_num, s17_den;
  logic s17_inv;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_sq_pp   <= mul_pp(s8_pv1, s8_pv1);
      s9_m5_pp   <= mul_pp(s8_pv1, c_p5x2);
      s9_m3_pp   <= mul_pp(c_p3, s8_pv1);
      s9_m2_pp   <= mul_pp(c_p2, s8_pv1);
      s9_pv1     <= s8_pv1;
      s10_sq     <= mul_fin(s9_sq_pp);
      s10_m5     <= mul_fin(s9_m5_pp);
      s10_m3     <= mul_fin(s9_m3_pp);
      s10_m2     <= mul_fin(s9_m2_pp);
      s10_pv1    <= s9_pv1;
      s11_x6_pp  <= mul_pp(s10_sq, c_p6);
      s11_x3_pp  <= mul_pp(s10_m3, s10_pv1);
      s11_m5     <= s10_m5;
      s11_m2     <= s10_m2;
      s12_x6     <= mul_fin(s11_x6_pp);
      s12_x3     <= mul_fin(s11_x3_pp);
      s12_m5     <= s11_m5;
      s12_m2     <= s11_m2;
      s13_v2a    <= fx_add(fx_shr(s12_x6, 15), s12_m5);
      s13_v1a    <= fx_add(fx_shr(s12_x3, 19), s12_m2);
      s14_v2b    <= fx_add(fx_shr(s13_v2a, 2), c_p4);
      s14_v1b    <= fx_add(FX_ONE, fx_shr(fx_shr(s13_v1a, 19), 15));
      s15_den_pp <= mul_pp(s14_v1b, c_p1);
      s15_pd     <= fx_sub(fx_from(fx_t'(64'd1048576 - {44'd0, rp_d[ST_RP_LAST]})),
                           fx_shr(s14_v2b, 12));
      s16_den    <= mul_fin(s15_den_pp);
      s16_num_pp <= mul_pp(s15_pd, FX_6250);
      s17_num    <= mul_fin(s16_num_pp);
      s17_den    <= s16_den;
      s17_inv    <= s16_den == '0;
    end
  end

  fx_t pq;

  esc_div u_div (
    .clk (clk),
    .en  (en),
    .num (s17_num),
    .den (s17_den),
    .quo (pq)
  );

  // ---------------------------------------------------------------------
  // pressure correction after the quotient
  // ---------------------------------------------------------------------
  mpp_t t1_p9_pp, t1_p8_pp;
  fx_t  t1_pq;
  fx_t  t2_w1a, t2_w2a, t2_pq;
  mpp_t t3_w1_pp;
  fx_t  t3_w2, t3_pq;
  fx_t  t4_w1, t4_w2, t4_pq;
  fx_t  t5_sa, t5_pq;
  fx_t  t6_pa;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_p9_pp <= mul_pp(c_p9, pq);
      t1_p8_pp <= mul_pp(pq, c_p8);
      t1_pq    <= pq;
      t2_w1a   <= mul_fin(t1_p9_pp);
      t2_w2a   <= mul_fin(t1_p8_pp);
      t2_pq    <= t1_pq;
      t3_w1_pp <= mul_pp(t2_w1a, t2_pq);
      t3_w2    <= fx_shr(t2_w2a, 15);
      t3_pq    <= t2_pq;
      t4_w1    <= fx_shr(mul_fin(t3_w1_pp), 31);
      t4_w2    <= t3_w2;
      t4_pq    <= t3_pq;
      t5_sa    <= fx_add(fx_add(t4_w1, t4_w2), c_p7);
      t5_pq    <= t4_pq;
      t6_pa    <= fx_add(t5_pq, fx_shr(t5_sa, 4));
    end
  end

  // ---------------------------------------------------------------------
  // humidity, stages 9..25
  // ---------------------------------------------------------------------
  mpp_t h9_h5_pp, h9_h3_pp, h9_h6_pp;
  fx_t  h10_f5, h10_f3, h10_f6;
  fx_t  h11_hb, h11_g1, h11_f6;
  fx_t  h12_ha;
  mpp_t h12_g_pp;
  fx_t  h13_gx, h13_ha;
  fx_t  h14_g2, h14_ha;
  mpp_t h15_h2_pp;
  fx_t  h15_ha;
  fx_t  h16_g3, h16_ha;
  mpp_t h17_pp;
  fx_t  h18_hm;
  mpp_t h19_pp;
  fx_t  h19_hm;
  fx_t  h20_y, h20_hm;
  mpp_t h21_pp;
  fx_t  h22_hz;
  fx_t  h23_hc;
  mpp_t h24_pp;
  fx_t  h25_raw;

  always_ff @(posedge clk) begin
    if (en) begin
      h9_h5_pp  <= mul_pp(c_h5, s8_hd);
      h9_h3_pp  <= mul_pp(c_h3, s8_hd);
      h9_h6_pp  <= mul_pp(c_h6, s8_hd);
      h10_f5    <= mul_fin(h9_h5_pp);
      h10_f3    <= mul_fin(h9_h3_pp);
      h10_f6    <= mul_fin(h9_h6_pp);
      h11_hb    <= fx_add(c_h4, fx_shr(h10_f5, 14));
      h11_g1    <= fx_add(FX_ONE, fx_shr(h10_f3, 26));
      h11_f6    <= h10_f6;
      h12_ha    <= fx_sub(fx_from({48'd0, rh_d[ST_RH_LAST]}), h11_hb);
      h12_g_pp  <= mul_pp(h11_f6, h11_g1);
      h13_gx    <= mul_fin(h12_g_pp);
      h13_ha    <= h12_ha;
      h14_g2    <= fx_add(FX_ONE, fx_shr(h13_gx, 26));
      h14_ha    <= h13_ha;
      h15_h2_pp <= mul_pp(c_h2, h14_g2);
      h15_ha    <= h14_ha;
      h16_g3    <= fx_shr(mul_fin(h15_h2_pp), 16);
      h16_ha    <= h15_ha;
      h17_pp    <= mul_pp(h16_ha, h16_g3);
      h18_hm    <= mul_fin(h17_pp);
      h19_pp    <= mul_pp(c_h1, h18_hm);
      h19_hm    <= h18_hm;
      h20_y     <= fx_sub(FX_ONE, fx_shr(mul_fin(h19_pp), 19));
      h20_hm    <= h19_hm;
      h21_pp    <= mul_pp(h20_hm, h20_y);
      h22_hz    <= mul_fin(h21_pp);
      // clamp to 0..100 %
      if (h22_hz > FX_100) begin
        h23_hc <= FX_100;
      end else if (h22_hz < 0) begin
        h23_hc <= '0;
      end else begin
        h23_hc <= h22_hz;
      end
      h24_pp    <= mul_pp(h23_hc, FX_100);
      h25_raw   <= fx_shr(mul_fin(h24_pp), FRAC_BITS);
    end
  end

  // ---------------------------------------------------------------------
  // align finished fields with the pressure result
  // ---------------------------------------------------------------------
  logic [15:0] tc_d  [ST_TC+1:ST_OUT-1];
  logic [13:0] hum_d [ST_HUM+1:ST_OUT-1];
  logic        inv_d [ST_INV+1:ST_OUT-1];
  logic [15:0] tc_sat;

  always_comb begin
    if (s9_tc > fx_t'(32767)) begin
      tc_sat = 16'h7FFF;
    end else if (s9_tc < fx_t'(-32768)) begin
      tc_sat = 16'h8000;
    end else begin
      tc_sat = s9_tc[15:0];
    end
  end

  // index of each delay register is the stage it belongs to
  always_ff @(posedge clk) begin
    if (en) begin
      tc_d[ST_TC+1]   <= tc_sat;
      hum_d[ST_HUM+1] <= h25_raw[13:0];
      inv_d[ST_INV+1] <= s17_inv;
      for (int k = ST_TC + 2; k <= ST_OUT - 1; k++) tc_d[k] <= tc_d[k-1];
      for (int k = ST_HUM + 2; k <= ST_OUT - 1; k++) hum_d[k] <= hum_d[k-1];
      for (int k = ST_INV + 2; k <= ST_OUT - 1; k++) inv_d[k] <= inv_d[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  fx_t         pa_round;
  logic [17:0] pa_sat;

  always_comb begin
    pa_round = fx_shr(t6_pa, FRAC_BITS);
    if (inv_d[ST_OUT-1]) begin
      pa_sat = '0;
    end else if (pa_round < 0) begin
      pa_sat = '0;
    end else if (pa_round > fx_t'(262143)) begin
      pa_sat = '1;
    end else begin
      pa_sat = pa_round[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {hum_d[ST_OUT-1], pa_sat, tc_d[ST_OUT-1]};
      m_tuser <= inv_d[ST_OUT-1];
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[1])
    else $error("accepted sample did not enter the pipeline");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[33:16] == 18'd0))
    else $error("invalid pressure with nonzero value");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[47:34] <= 14'd10000))
    else $error("humidity above full scale");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (vld[ST_OUT] && !m_tready) |=> (vld[ST_OUT] && $stable(vld)))
    else $error("pipeline moved while output stalled");

endmodule
`default_nettype wire

// ===== tb/env_sensor_compensation_tb.sv =====
// env_sensor_compensation_tb: self-checking testbench for the sensor compensation
// block; drives raw samples and calibration over the stream and register ports
// and checks every result against an in-bench fixed-point predictor
`timescale 1ns / 1ps
module env_sensor_compensation_tb;

  typedef logic signed [63:0] fxv_t;

  // one expected compensated result
  typedef struct packed {
    logic [15:0] temp_centi;
    logic [17:0] press_pa;
    logic        press_bad;
    logic [13:0] hum_centi;
  } comp_result_t;

  // register byte addresses (64-bit data, 8 bytes apart)
  localparam logic [5:0] ADDR_TEMP_CAL  = 6'h00;
  localparam logic [5:0] ADDR_PRESS_A   = 6'h08;
  localparam logic [5:0] ADDR_PRESS_B   = 6'h10;
  localparam logic [5:0] ADDR_PRESS_NINE = 6'h18;
  localparam logic [5:0] ADDR_HUM_CAL   = 6'h20;
  localparam logic [5:0] ADDR_UNMAPPED  = 6'h28;

  localparam int   FRAC        = 24;
  localparam fxv_t FXV_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int   DRAIN_WAIT  = 120;   // longer than the pipeline is deep
  localparam int   STALL_LIMIT = 3000;  // cycles with no transaction at all
  localparam int   LONG_HOLD   = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;

  env_sensor_compensation uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the calibration registers used by the predictor
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a, cal_press_b, cal_hum;
  logic [15:0] cal_press_nine;

  comp_result_t pending_results[$];
  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int settings_used = 0;

  // sender pacing
  int  tx_gap = 0;
  bit  tx_high = 0;
  bit  tx_no_gaps = 0;
  // receiver pacing
  bit  rx_no_stall = 0;
  bit  rx_hold_request = 0;
  int  rx_hold_left = 0;
  int  rx_wait = 0;
  int  idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // fixed-point predictor: 64-bit signed words with 24 fraction bits,
  // saturating sums, rounded magnitudes for products, quotients and shifts
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] abs_val(fxv_t a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  function automatic fxv_t signed_of(logic neg, logic [63:0] m);
    logic [63:0] c;
    c = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
    return neg ? fxv_t'(~c + 64'd1) : fxv_t'(c);
  endfunction

  function automatic fxv_t to_fixed(fxv_t n);
    fxv_t lim;
    lim = FXV_MAX >>> FRAC;
    if (n > lim) return FXV_MAX;
    if (n < -lim) return -FXV_MAX;
    return n <<< FRAC;
  endfunction

  function automatic fxv_t sat_add(fxv_t a, fxv_t b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? fxv_t'(64'h8000_0000_0000_0000) : FXV_MAX;
    return fxv_t'(s[63:0]);
  endfunction

  function automatic fxv_t sat_sub(fxv_t a, fxv_t b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? fxv_t'(64'h8000_0000_0000_0000) : FXV_MAX;
    return fxv_t'(s[63:0]);
  endfunction

  // divide by 2^s, rounded to nearest with ties away from zero
  function automatic fxv_t round_shift(fxv_t a, int s);
    logic [64:0] t;
    t = ({1'b0, abs_val(a)} + (65'd1 << (s - 1))) >> s;
    return signed_of(a[63], t[63:0]);
  endfunction

  function automatic fxv_t fixed_mul(fxv_t a, fxv_t b);
    logic [127:0] pr;
    pr = {64'd0, abs_val(a)} * {64'd0, abs_val(b)};
    pr = (pr + (128'd1 << (FRAC - 1))) >> FRAC;
    return signed_of(a[63] ^ b[63], (|pr[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : pr[63:0]);
  endfunction

  function automatic fxv_t fixed_div(fxv_t a, fxv_t b);
    logic [127:0] num, q;
    logic [63:0]  ub;
    ub  = abs_val(b);
    if (ub == 64'd0) return '0;
    num = ({64'd0, abs_val(a)} << FRAC) + {64'd0, ub >> 1};
    if (num[127:64] >= ub) return signed_of(a[63] ^ b[63], 64'hFFFF_FFFF_FFFF_FFFF);
    q = num / {64'd0, ub};
    return signed_of(a[63] ^ b[63], q[63:0]);
  endfunction

  function automatic comp_result_t compensate(logic [19:0] raw_p, logic [19:0] raw_t,
                                              logic [15:0] raw_h);
    comp_result_t r;
    fxv_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
    fxv_t one, a, b, v1, v2, tsum, fine, tc, p, w1, w2, pa, h, g;
    t1 = fxv_t'({48'd0, cal_temp[15:0]});
    t2 = fxv_t'($signed(cal_temp[31:16]));
    t3 = fxv_t'($signed(cal_temp[47:32]));
    p1 = fxv_t'({48'd0, cal_press_a[15:0]});
    p2 = fxv_t'($signed(cal_press_a[31:16]));
    p3 = fxv_t'($signed(cal_press_a[47:32]));
    p4 = fxv_t'($signed(cal_press_a[63:48]));
    p5 = fxv_t'($signed(cal_press_b[15:0]));
    p6 = fxv_t'($signed(cal_press_b[31:16]));
    p7 = fxv_t'($signed(cal_press_b[47:32]));
    p8 = fxv_t'($signed(cal_press_b[63:48]));
    p9 = fxv_t'($signed(cal_press_nine));
    h1 = fxv_t'({56'd0, cal_hum[7:0]});
    h2 = fxv_t'($signed(cal_hum[23:8]));
    h3 = fxv_t'({56'd0, cal_hum[31:24]});
    h4 = fxv_t'($signed(cal_hum[43:32]));
    h5 = fxv_t'($signed(cal_hum[55:44]));
    h6 = fxv_t'($signed(cal_hum[63:56]));
    one = to_fixed(64'sd1);

    // temperature and the fine temperature term
    a  = sat_sub(round_shift(to_fixed({44'd0, raw_t}), 14), round_shift(to_fixed(t1), 10));
    v1 = fixed_mul(a, to_fixed(t2));
    b  = sat_sub(round_shift(to_fixed({44'd0, raw_t}), 17), round_shift(to_fixed(t1), 13));
    v2 = fixed_mul(fixed_mul(b, b), to_fixed(t3));
    tsum = sat_add(v1, v2);
    fine = signed_of(tsum[63], abs_val(tsum) >> FRAC);
    tc = round_shift(fixed_mul(tsum, to_fixed(64'sd5)), FRAC + 8);
    if (tc > 64'sd32767) tc = 64'sd32767;
    if (tc < -64'sd32768) tc = -64'sd32768;
    fine = to_fixed(fine);

    // pressure
    v1 = sat_sub(round_shift(fine, 1), to_fixed(64'sd64000));
    v2 = sat_add(round_shift(fixed_mul(fixed_mul(v1, v1), to_fixed(p6)), 15),
                 fixed_mul(v1, to_fixed(2 * p5)));
    v2 = sat_add(round_shift(v2, 2), to_fixed(p4 * 65536));
    v1 = round_shift(sat_add(round_shift(fixed_mul(fixed_mul(to_fixed(p3), v1), v1), 19),
                             fixed_mul(to_fixed(p2), v1)), 19);
    v1 = fixed_mul(sat_add(one, round_shift(v1, 15)), to_fixed(p1));
    r.press_bad = (v1 == 0);
    if (v1 == 0) begin
      pa = 0;
    end else begin
      p  = to_fixed(64'sd1048576 - fxv_t'({44'd0, raw_p}));
      p  = fixed_div(fixed_mul(sat_sub(p, round_shift(v2, 12)), to_fixed(64'sd6250)), v1);
      w1 = round_shift(fixed_mul(fixed_mul(to_fixed(p9), p), p), 31);
      w2 = round_shift(fixed_mul(p, to_fixed(p8)), 15);
      pa = sat_add(p, round_shift(sat_add(sat_add(w1, w2), to_fixed(p7)), 4));
      pa = round_shift(pa, FRAC);
      if (pa < 0) pa = 0;
      if (pa > 64'sd262143) pa = 64'sd262143;
    end

    // humidity, clamped to 0..100 before scaling
    h = sat_sub(fine, to_fixed(64'sd76800));
    a = sat_sub(to_fixed({48'd0, raw_h}),
                sat_add(to_fixed(h4 * 64), round_shift(fixed_mul(to_fixed(h5), h), 14)));
    g = sat_add(one, round_shift(fixed_mul(to_fixed(h3), h), 26));
    g = sat_add(one, round_shift(fixed_mul(fixed_mul(to_fixed(h6), h), g), 26));
    g = round_shift(fixed_mul(to_fixed(h2), g), 16);
    h = fixed_mul(a, g);
    h = fixed_mul(h, sat_sub(one, round_shift(fixed_mul(to_fixed(h1), h), 19)));
    if (h > to_fixed(64'sd100)) h = to_fixed(64'sd100);
    if (h < 0) h = 0;
    h = round_shift(fixed_mul(h, to_fixed(64'sd100)), FRAC);

    r.temp_centi = tc[15:0];
    r.press_pa   = pa[17:0];
    r.hum_centi  = h[13:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // register port
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [5:0] addr, logic [63:0] value);
    logic [63:0] rd;
    logic [63:0] mask;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register written at this edge; turn straight into a read-back transaction
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    case (addr)
      ADDR_TEMP_CAL: begin
        cal_temp = value[47:0]; mask = 64'h0000_FFFF_FFFF_FFFF;
      end
      ADDR_PRESS_A: begin
        cal_press_a = value; mask = '1;
      end
      ADDR_PRESS_B: begin
        cal_press_b = value; mask = '1;
      end
      ADDR_PRESS_NINE: begin
        cal_press_nine = value[15:0]; mask = 64'hFFFF;
      end
      ADDR_HUM_CAL: begin
        cal_hum = value; mask = '1;
      end
      default: mask = '0;  // unmapped: write does nothing, read not checked
    endcase
    if ((rd & mask) != (value & mask)) report_mismatch("register readback", rd & mask, value & mask);
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                                  logic [15:0] p9, logic [63:0] hc);
    write_reg(ADDR_TEMP_CAL, {16'd0, tc});
    write_reg(ADDR_PRESS_A, pa);
    write_reg(ADDR_PRESS_B, pb);
    write_reg(ADDR_PRESS_NINE, {48'd0, p9});
    write_reg(ADDR_HUM_CAL, hc);
    settings_used++;
  endtask

  // a typical factory calibration set
  task automatic load_typical_calibration();
    load_calibration({16'hFC18, 16'd26435, 16'd27504},
                     {16'd2855, 16'd3024, 16'hD643, 16'd36477},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140},
                     16'd6000,
                     {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
  endtask

  task automatic load_random_calibration();
    load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                     16'($urandom), {$urandom, $urandom});
  endtask

  // ---------------------------------------------------------------------------
  // sample stream: sender and result checker
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  task automatic send_sample(logic [19:0] raw_p, logic [19:0] raw_t, logic [15:0] raw_h);
    repeat (tx_gap) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {raw_h, raw_t, raw_p};
    tx_high = 1;
    do @(posedge clk); while (!s_tready);
    // transaction accepted at this edge: predict now with the live calibration
    pending_results.push_back(compensate(raw_p, raw_t, raw_h));
    samples_sent++;
    tx_gap = tx_no_gaps ? 0 : $urandom_range(0, 9);
    if (tx_gap > 0) begin
      s_tvalid <= 1'b0;
      tx_high = 0;
    end
  endtask

  // near the usual operating point, or anywhere in the field range
  task automatic send_random_sample(bit typical);
    if (typical)
      send_sample(20'(415148 + $urandom_range(0, 200000) - 100000),
                  20'(519888 + $urandom_range(0, 120000) - 60000),
                  16'(30000 + $urandom_range(0, 30000) - 15000));
    else
      send_sample(20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  // let everything expected come out, then a pipeline's worth of cycles more
  task automatic drain_pipeline();
    if (tx_high) begin
      s_tvalid <= 1'b0;
      tx_high = 0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    tx_gap = 0;
  endtask

  // receiver: checks each result transaction and paces tready
  always @(posedge clk) begin
    comp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'({m_tuser, m_tdata}), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[15:0] != want.temp_centi)
          report_mismatch("temperature_centi", 64'(m_tdata[15:0]), 64'(want.temp_centi));
        if (m_tdata[33:16] != want.press_pa)
          report_mismatch("pressure_pa", 64'(m_tdata[33:16]), 64'(want.press_pa));
        if (m_tdata[47:34] != want.hum_centi)
          report_mismatch("humidity_centi", 64'(m_tdata[47:34]), 64'(want.hum_centi));
        if (m_tuser != want.press_bad)
          report_mismatch("pressure_invalid", 64'(m_tuser), 64'(want.press_bad));
      end
    end
    if (rx_hold_request) begin
      // long hold-off so the pipeline fills and pushes back on the input
      rx_hold_request <= 1'b0;
      rx_hold_left = LONG_HOLD;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !rx_no_stall) rx_wait = $urandom_range(0, 9);
      m_tready <= (rx_wait == 0);
    end
  end

  // watchdog: any stretch without a transaction beyond the limit is a hang
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // after reset every calibration word is zero: pressure divisor is zero
  task automatic test_reset_calibration();
    cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_press_nine = '0; cal_hum = '0;
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_sample(20'd415148, 20'd519888, 16'd30000);
    drain_pipeline();
  endtask

  // field extremes and the usual operating point with a real calibration
  task automatic test_directed_extremes();
    load_typical_calibration();
    send_sample(20'd415148, 20'd519888, 16'd30000);
    send_sample(20'd0, 20'd519888, 16'd30000);
    send_sample(20'hFFFFF, 20'd519888, 16'd30000);
    send_sample(20'd415148, 20'd0, 16'd30000);
    send_sample(20'd415148, 20'hFFFFF, 16'd30000);
    // humidity clamp at both ends
    send_sample(20'd415148, 20'd519888, 16'd0);
    send_sample(20'd415148, 20'd519888, 16'hFFFF);
    send_sample(20'd0, 20'd0, 16'd0);
    send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    drain_pipeline();
    // zero P1 makes the pressure divisor zero: invalid flag
    load_calibration({16'hFC18, 16'd26435, 16'd27504}, {16'd2855, 16'd3024, 16'hD643, 16'd0},
                     {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000,
                     {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
    send_sample(20'd415148, 20'd519888, 16'd30000);
    send_sample(20'hFFFFF, 20'd0, 16'hFFFF);
    drain_pipeline();
    // maximal coefficients: temperature and intermediates saturate
    load_calibration({16'h7FFF, 16'h7FFF, 16'h0000}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
                     {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 16'h7FFF,
                     {8'h7F, 12'h7FF, 12'h7FF, 8'hFF, 16'h7FFF, 8'hFF});
    send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
    send_sample(20'hFFFFF, 20'd0, 16'd0);
    send_sample(20'd415148, 20'd519888, 16'd30000);
    drain_pipeline();
    // most negative coefficients
    load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
                     {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000,
                     {8'h80, 12'h800, 12'h800, 8'h00, 16'h8000, 8'h00});
    send_sample(20'd0, 20'hFFFFF, 16'hFFFF);
    send_sample(20'hFFFFF, 20'd0, 16'd0);
    send_sample(20'd415148, 20'd519888, 16'd30000);
    drain_pipeline();
    // an address past the register map changes nothing
    write_reg(ADDR_UNMAPPED, '1);
    send_sample(20'd415148, 20'd519888, 16'd30000);
    drain_pipeline();
  endtask

  task automatic test_typical_random(int count);
    load_typical_calibration();
    repeat (count) send_random_sample($urandom_range(0, 3) != 0);
    drain_pipeline();
  endtask

  task automatic test_random_calibration(int phases, int count);
    repeat (phases) begin
      load_random_calibration();
      repeat (count) send_random_sample($urandom_range(0, 1));
      drain_pipeline();
    end
  endtask

  // full rate on both sides, then a long receiver hold-off mid-stream
  task automatic test_back_pressure(int count);
    load_typical_calibration();
    tx_no_gaps = 1;
    rx_no_stall = 1;
    tx_gap = 0;
    repeat (count / 2) send_random_sample(1);
    rx_hold_request <= 1'b1;
    repeat (count - count / 2) send_random_sample(1);
    tx_no_gaps = 0;
    rx_no_stall = 0;
    drain_pipeline();
  endtask

  // sender stops in bursts until every outstanding result has come back
  task automatic test_burst_then_drain(int bursts, int count);
    load_random_calibration();
    repeat (bursts) begin
      repeat (count) send_random_sample($urandom_range(0, 1));
      if (tx_high) begin
        s_tvalid <= 1'b0;
        tx_high = 0;
      end
      while (pending_results.size() != 0) @(posedge clk);
      tx_gap = 0;
    end
    drain_pipeline();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_calibration();
    test_directed_extremes();
    test_typical_random(450);
    test_random_calibration(4, 200);
    test_back_pressure(300);
    test_burst_then_drain(8, 25);
    drain_pipeline();
    $display("sent %0d raw samples across %0d calibration settings, checked %0d results",
             samples_sent, settings_used, results_seen);
    $display("stimulus included stalls on both sides, a long output hold-off and drains");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
